[hw/rtl/review_schedule_table_top_macros.svh]
// Assertion macros used by the checker file.
`ifndef REVIEW_SCHEDULE_TABLE_TOP_MACROS_SVH
`define REVIEW_SCHEDULE_TABLE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define RVS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("review schedule table check failed");

// Next-cycle implication, sampled on clk and idle during reset.
`define RVS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("review schedule table check failed");

`endif

[hw/rtl/rvs_pkg.sv]
`timescale 1ns / 1ps
package rvs_pkg;

  localparam int PAGE_W  = 16;
  localparam int STEP_W  = 3;
  localparam int DAY_W   = 20;
  localparam int DUE_W   = DAY_W + 1;
  localparam int WORD_W  = PAGE_W + STEP_W + DAY_W;
  localparam int MAX_RESULTS = 32;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ADD    = 2'd0;
  localparam kind_t KIND_REVIEW = 2'd1;
  localparam kind_t KIND_DUE    = 2'd2;

  typedef struct packed {
    logic             due;
    logic             earlier;
    logic [DUE_W-1:0] due_day;
  } cmp_t;

  function automatic logic [8:0] interval_of(input logic [STEP_W-1:0] s);
    logic [8:0] r;
    case (s)
      3'd0: r = 9'd1;
      3'd1: r = 9'd3;
      3'd2: r = 9'd7;
      3'd3: r = 9'd14;
      3'd4: r = 9'd30;
      3'd5: r = 9'd90;
      3'd6: r = 9'd180;
      default: r = 9'd365;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/rvs_cmd_if.sv]
`timescale 1ns / 1ps
interface rvs_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] page;
  logic [19:0] day;
  logic [4:0]  entry_index;
  logic [5:0]  max_out;

  modport source (output valid, kind, page, day, entry_index, max_out, input ready);
  modport sink (input valid, kind, page, day, entry_index, max_out, output ready);
endinterface

[hw/rtl/rvs_res_if.sv]
`timescale 1ns / 1ps
interface rvs_res_if;
  logic        valid;
  logic        ready;
  logic [4:0]  due_index;
  logic        due_valid;
  logic [5:0]  due_total;
  logic        accepted;
  logic [15:0] next_page;
  logic [5:0]  entry_count;
  logic        last;

  modport source (output valid, due_index, due_valid, due_total, accepted, next_page,
                  entry_count, last, input ready);
  modport sink (input valid, due_index, due_valid, due_total, accepted, next_page,
                entry_count, last, output ready);
endinterface

[hw/rtl/rvs_ram.sv]
`timescale 1ns / 1ps
module rvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[hw/rtl/rvs_cmp.sv]
`timescale 1ns / 1ps
// Shared compare unit: due test of one entry and its order against the best so far.
module rvs_cmp #(
  parameter int STEP_COUNT = 8
) (
  input  logic [rvs_pkg::WORD_W-1:0] word,
  input  logic [rvs_pkg::DAY_W-1:0]  day,
  input  logic [rvs_pkg::DUE_W-1:0]  best_due,
  input  logic [rvs_pkg::DAY_W-1:0]  best_start,
  input  logic [rvs_pkg::PAGE_W-1:0] best_page,
  output rvs_pkg::cmp_t              res
);
  logic [rvs_pkg::PAGE_W-1:0] page;
  logic [rvs_pkg::STEP_W-1:0] step;
  logic [rvs_pkg::DAY_W-1:0]  start;
  logic [rvs_pkg::DUE_W-1:0]  dd;

  assign page  = word[rvs_pkg::WORD_W-1 -: rvs_pkg::PAGE_W];
  assign step  = word[rvs_pkg::DAY_W +: rvs_pkg::STEP_W];
  assign start = word[rvs_pkg::DAY_W-1:0];
  assign dd    = rvs_pkg::DUE_W'(start) + rvs_pkg::DUE_W'(rvs_pkg::interval_of(step));

  always_comb begin
    res.due_day = dd;
    res.due     = (32'(step) < STEP_COUNT) && (rvs_pkg::DUE_W'(day) >= dd);
    res.earlier = (dd < best_due) ||
                  ((dd == best_due) && ((start < best_start) ||
                   ((start == best_start) && (page < best_page))));
  end
endmodule

[hw/rtl/review_schedule_table_top.sv]
`timescale 1ns / 1ps
// Spaced-review schedule table.
// Commands arrive on cmd (valid/ready); results leave on res (valid/ready), one beat
// per result, the final beat of each command flagged by last. cmd.ready is high only
// while the sequencer is idle; one command is worked at a time.
// The table sits in one RAM with a write port and a registered read port, walked one entry
// at a time (address, then registered data into the shared compare unit).
// A due list first takes one pass over the table to count the due entries; each emitted
// beat after that is a fresh minimum search over the table.
// A result beat holds in the output register until res.ready; the walk waits there,
// so a stalled receiver simply stretches the command.
// Reset empties the table and clears the highest page; no clearing pass is needed,
// as entries at or beyond the count are never read.
module review_schedule_table_top #(
  parameter int TABLE_DEPTH = 32,
  parameter int STEP_COUNT  = 8
) (
  input logic      clk,
  input logic      rst,
  rvs_cmd_if.sink  cmd,
  rvs_res_if.source res
);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = 7;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CHK  = 5'b00100,
    S_APP  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;
  logic [CW-1:0] total;
  logic [rvs_pkg::PAGE_W-1:0] highest;

  rvs_pkg::kind_t             kind_q;
  logic [rvs_pkg::PAGE_W-1:0] page_q;
  logic [rvs_pkg::DAY_W-1:0]  day_q;
  logic [5:0]                 max_q;
  logic [IW-1:0]              idx;
  logic                       phase;
  logic [TABLE_DEPTH-1:0]     due_bits;
  logic [TABLE_DEPTH-1:0]     taken;
  logic [CW-1:0]              cnt;
  logic [EW-1:0]              emit;
  logic [EW-1:0]              k;
  logic                       have_best;
  logic [IW-1:0]              best_idx;
  logic [rvs_pkg::DUE_W-1:0]  best_due;
  logic [rvs_pkg::DAY_W-1:0]  best_start;
  logic [rvs_pkg::PAGE_W-1:0] best_page;

  logic [4:0] o_idx;
  logic       o_dv;
  logic [5:0] o_total;
  logic       o_acc;
  logic       o_last;

  logic                       we;
  logic [IW-1:0]              waddr;
  logic [rvs_pkg::WORD_W-1:0] wdata;
  logic [rvs_pkg::WORD_W-1:0] rdata;
  logic [rvs_pkg::PAGE_W-1:0] rd_page;
  logic [rvs_pkg::STEP_W-1:0] rd_step;
  logic [rvs_pkg::DAY_W-1:0]  rd_start;
  logic [rvs_pkg::STEP_W-1:0] step_up;
  rvs_pkg::cmp_t              cmpo;

  logic          at_end;
  logic          room;
  logic          hit;
  logic          take;
  logic [IW-1:0] sel_idx;
  logic [CW-1:0] cnt_next;
  logic [EW-1:0] emit_next;

  assign rd_page  = rdata[rvs_pkg::WORD_W-1 -: rvs_pkg::PAGE_W];
  assign rd_step  = rdata[rvs_pkg::DAY_W +: rvs_pkg::STEP_W];
  assign rd_start = rdata[rvs_pkg::DAY_W-1:0];
  assign step_up  = (32'(rd_step) + 1 < STEP_COUNT) ? rd_step + 3'd1 : rd_step;

  assign at_end   = (CW'(idx) + CW'(1)) == total;
  assign room     = 32'(total) < TABLE_DEPTH;
  assign hit      = rd_page == page_q;
  assign take     = due_bits[idx] && !taken[idx] && (!have_best || cmpo.earlier);
  assign sel_idx  = take ? idx : best_idx;
  assign cnt_next = cnt + CW'(cmpo.due);

  always_comb begin
    emit_next = EW'(cnt_next);
    if (EW'(max_q) < emit_next) begin
      emit_next = EW'(max_q);
    end
    if (EW'(rvs_pkg::MAX_RESULTS) < emit_next) begin
      emit_next = EW'(rvs_pkg::MAX_RESULTS);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = {page_q, 3'd0, day_q};
    if (state == S_APP) begin
      we    = room;
      waddr = IW'(total);
    end else if (state == S_CHK && kind_q == rvs_pkg::KIND_ADD) begin
      we = hit;
    end else if (state == S_CHK && kind_q == rvs_pkg::KIND_REVIEW) begin
      we    = 1'b1;
      wdata = {rd_page, step_up, rd_start};
    end
  end

  rvs_ram #(
    .WIDTH(rvs_pkg::WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (state == S_RD),
    .raddr(idx),
    .rdata(rdata)
  );

  rvs_cmp #(
    .STEP_COUNT(STEP_COUNT)
  ) u_cmp (
    .word      (rdata),
    .day       (day_q),
    .best_due  (best_due),
    .best_start(best_start),
    .best_page (best_page),
    .res       (cmpo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      total   <= '0;
      highest <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            kind_q    <= cmd.kind;
            page_q    <= cmd.page;
            day_q     <= cmd.day;
            max_q     <= cmd.max_out;
            due_bits  <= '0;
            taken     <= '0;
            cnt       <= '0;
            phase     <= 1'b0;
            have_best <= 1'b0;
            k         <= '0;
            idx       <= '0;
            o_idx     <= '0;
            o_dv      <= 1'b0;
            o_total   <= '0;
            o_last    <= 1'b1;
            case (cmd.kind)
              rvs_pkg::KIND_ADD: begin
                if (cmd.page > highest) begin
                  highest <= cmd.page;
                end
                state <= (total == '0) ? S_APP : S_RD;
              end
              rvs_pkg::KIND_REVIEW: begin
                if (32'(cmd.entry_index) < 32'(total)) begin
                  idx   <= IW'(cmd.entry_index);
                  state <= S_RD;
                end else begin
                  o_acc <= 1'b0;
                  state <= S_OUT;
                end
              end
              rvs_pkg::KIND_DUE: begin
                if (total == '0) begin
                  o_acc <= 1'b1;
                  state <= S_OUT;
                end else begin
                  state <= S_RD;
                end
              end
              default: begin
                o_acc <= 1'b0;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          case (kind_q)
            rvs_pkg::KIND_ADD: begin
              if (hit) begin
                o_acc <= 1'b1;
                state <= S_OUT;
              end else if (at_end) begin
                state <= S_APP;
              end else begin
                idx   <= idx + IW'(1);
                state <= S_RD;
              end
            end
            rvs_pkg::KIND_REVIEW: begin
              o_acc <= 1'b1;
              state <= S_OUT;
            end
            default: begin
              if (!phase) begin
                if (cmpo.due) begin
                  due_bits[idx] <= 1'b1;
                end
                cnt <= cnt_next;
                if (at_end) begin
                  emit    <= emit_next;
                  o_total <= 6'(cnt_next);
                  o_acc   <= 1'b1;
                  if (emit_next == '0) begin
                    state <= S_OUT;
                  end else begin
                    phase <= 1'b1;
                    idx   <= '0;
                    state <= S_RD;
                  end
                end else begin
                  idx   <= idx + IW'(1);
                  state <= S_RD;
                end
              end else begin
                if (take) begin
                  have_best  <= 1'b1;
                  best_idx   <= idx;
                  best_due   <= cmpo.due_day;
                  best_start <= rd_start;
                  best_page  <= rd_page;
                end
                if (at_end) begin
                  // The winner of this pass is final; retire it from later passes.
                  taken[sel_idx] <= 1'b1;
                  o_idx          <= 5'(sel_idx);
                  o_dv           <= 1'b1;
                  o_last         <= (k + EW'(1)) == emit;
                  k              <= k + EW'(1);
                  state          <= S_OUT;
                end else begin
                  idx   <= idx + IW'(1);
                  state <= S_RD;
                end
              end
            end
          endcase
        end
        S_APP: begin
          if (room) begin
            total <= total + CW'(1);
            o_acc <= 1'b1;
          end else begin
            o_acc <= 1'b0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (res.ready) begin
            if (!o_last) begin
              idx       <= '0;
              have_best <= 1'b0;
              state     <= S_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd.ready       = state == S_IDLE;
  assign res.valid       = state == S_OUT;
  assign res.due_index   = o_idx;
  assign res.due_valid   = o_dv;
  assign res.due_total   = o_total;
  assign res.accepted    = o_acc;
  assign res.next_page   = highest + 16'd1;
  assign res.entry_count = 6'(total);
  assign res.last        = o_last;
endmodule

[hw/rtl/rvs_chk.sv]
`timescale 1ns / 1ps
`include "review_schedule_table_top_macros.svh"
module rvs_chk (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       res_due_valid,
  input logic       res_accepted,
  input logic       res_last
);
  // A stalled result beat stays offered.
  `RVS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
  // Only one command is in flight at a time.
  `RVS_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready)
  `RVS_ASSERT_NOW(a_no_accept_while_out, res_valid, !cmd_ready)
  // Emitted due entries come only from an accepted due list.
  `RVS_ASSERT_NOW(a_due_accepted, res_valid && res_due_valid, res_accepted)
  // A beat without a due entry is always the only beat of its command.
  `RVS_ASSERT_NOW(a_plain_is_last, res_valid && !res_due_valid, res_last)
endmodule

bind review_schedule_table_top rvs_chk u_rvs_chk (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_due_valid(res.due_valid),
  .res_accepted (res.accepted),
  .res_last     (res.last)
);

[tb/tb_review_schedule_table_top.sv]
`timescale 1ns / 1ps
module tb_review_schedule_table_top;

  localparam rvs_pkg::kind_t KIND_UNUSED = 2'd3;
  localparam int DEPTH = 32;
  localparam int unsigned GAP_DAYS [8] = '{1, 3, 7, 14, 30, 90, 180, 365};

  typedef struct {
    rvs_pkg::kind_t kind;
    logic [15:0]    page;
    logic [19:0]    day;
    logic [4:0]     entry_index;
    logic [5:0]     max_out;
  } command_t;

  typedef struct {
    logic [4:0]  due_index;
    logic        due_valid;
    logic [5:0]  due_total;
    logic        accepted;
    logic [15:0] next_page;
    logic [5:0]  entry_count;
    logic        last;
  } outcome_t;

  logic clk;
  logic rst;
  rvs_cmd_if cmd ();
  rvs_res_if res ();

  review_schedule_table_top dut (.clk(clk), .rst(rst), .cmd(cmd), .res(res));

  // Shadow copy of the table.
  logic [15:0] tbl_page [DEPTH];
  logic [2:0]  tbl_step [DEPTH];
  logic [19:0] tbl_start [DEPTH];
  int          tbl_count;
  logic [15:0] top_page;

  command_t pending_cmds [$];
  outcome_t due_outcomes [$];
  command_t in_flight;
  int       errors;
  int       send_gap;
  int       recv_stall;
  int       hold_left;
  int       holds_asked;
  int       holds_served;
  bit       quiet;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic logic [15:0] suggested_page();
    int unsigned best;
    best = top_page;
    if (best == 0) begin
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_page[i] > best) best = tbl_page[i];
      end
    end
    return 16'(best + 1);
  endfunction

  function automatic int unsigned due_day_of(int i);
    return int'(tbl_start[i]) + GAP_DAYS[tbl_step[i]];
  endfunction

  function automatic bit earlier_than(int a, int b);
    if (due_day_of(a) != due_day_of(b)) return due_day_of(a) < due_day_of(b);
    if (tbl_start[a] != tbl_start[b]) return tbl_start[a] < tbl_start[b];
    if (tbl_page[a] != tbl_page[b]) return tbl_page[a] < tbl_page[b];
    return a < b;
  endfunction

  function automatic void push_outcome(int idx, bit dv, int total, bit acc, bit fin);
    outcome_t o;
    o.due_index   = 5'(idx);
    o.due_valid   = dv;
    o.due_total   = 6'(total);
    o.accepted    = acc;
    o.next_page   = suggested_page();
    o.entry_count = 6'(tbl_count);
    o.last        = fin;
    due_outcomes.push_back(o);
  endfunction

  function automatic void predict_results(command_t c);
    bit is_due [DEPTH];
    bit taken [DEPTH];
    bit found;
    bit acc;
    int total;
    int emit;
    int best;
    case (c.kind)
      rvs_pkg::KIND_ADD: begin
        found = 0;
        acc = 1;
        for (int i = 0; i < tbl_count; i++) begin
          if (!found && tbl_page[i] == c.page) begin
            tbl_step[i] = 0;
            tbl_start[i] = c.day;
            found = 1;
          end
        end
        if (!found) begin
          if (tbl_count < DEPTH) begin
            tbl_page[tbl_count] = c.page;
            tbl_step[tbl_count] = 0;
            tbl_start[tbl_count] = c.day;
            tbl_count++;
          end else begin
            acc = 0;
          end
        end
        if (c.page > top_page) top_page = c.page;
        push_outcome(0, 0, 0, acc, 1);
      end
      rvs_pkg::KIND_REVIEW: begin
        acc = c.entry_index < tbl_count;
        if (acc && tbl_step[c.entry_index] != 3'd7) tbl_step[c.entry_index]++;
        push_outcome(0, 0, 0, acc, 1);
      end
      rvs_pkg::KIND_DUE: begin
        total = 0;
        for (int i = 0; i < DEPTH; i++) begin
          is_due[i] = i < tbl_count && int'(c.day) >= due_day_of(i);
          taken[i] = 0;
          if (is_due[i]) total++;
        end
        emit = total < c.max_out ? total : c.max_out;
        if (emit > rvs_pkg::MAX_RESULTS) emit = rvs_pkg::MAX_RESULTS;
        if (emit == 0) push_outcome(0, 0, total, 1, 1);
        for (int k = 0; k < emit; k++) begin
          best = -1;
          for (int i = 0; i < DEPTH; i++) begin
            if (is_due[i] && !taken[i] && (best < 0 || earlier_than(i, best))) best = i;
          end
          taken[best] = 1;
          push_outcome(best, 1, total, 1, k == emit - 1);
        end
      end
      default: push_outcome(0, 0, 0, 0, 1);
    endcase
  endfunction

  // Driver: one command beat at a time from the pending queue.
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cmd.valid && cmd.ready) predict_results(in_flight);
      if (!cmd.valid || cmd.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          cmd.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          in_flight = pending_cmds.pop_front();
          cmd.kind        <= in_flight.kind;
          cmd.page        <= in_flight.page;
          cmd.day         <= in_flight.day;
          cmd.entry_index <= in_flight.entry_index;
          cmd.max_out     <= in_flight.max_out;
          cmd.valid       <= 1'b1;
          if (!quiet && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 14);
        end else begin
          cmd.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, including the long hold-off asked by the sequence.
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      recv_stall = 0;
      hold_left = 0;
    end else begin
      if (holds_served < holds_asked) begin
        holds_served++;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) recv_stall = $urandom_range(1, 14);
      end
    end
  end

  // Monitor: every result beat against the oldest expectation.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && res.valid && res.ready) begin
      if (due_outcomes.size() == 0) begin
        report("unexpected beat, due_index", res.due_index, 0);
      end else begin
        want = due_outcomes.pop_front();
        if (res.due_index !== want.due_index) report("due_index", res.due_index, want.due_index);
        if (res.due_valid !== want.due_valid) report("due_valid", res.due_valid, want.due_valid);
        if (res.due_total !== want.due_total) report("due_total", res.due_total, want.due_total);
        if (res.accepted !== want.accepted) report("accepted", res.accepted, want.accepted);
        if (res.next_page !== want.next_page) report("next_page", res.next_page, want.next_page);
        if (res.entry_count !== want.entry_count)
          report("entry_count", res.entry_count, want.entry_count);
        if (res.last !== want.last) report("last", res.last, want.last);
      end
    end
  end

  task automatic queue_cmd(input rvs_pkg::kind_t k, input int pg, input int d, input int idx,
                           input int mo);
    command_t c;
    c.kind = k;
    c.page = 16'(pg);
    c.day = 20'(d);
    c.entry_index = 5'(idx);
    c.max_out = 6'(mo);
    pending_cmds.push_back(c);
  endtask

  // Checked away from the active edge so the driver's updates have settled.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_cmds.size() > 0 || cmd.valid || due_outcomes.size() > 0) @(negedge clk);
  endtask

  // Random commands around a moving base day so that entries come due.
  task automatic queue_random(input int count, input int base);
    int r;
    int d;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      d = base + $urandom_range(0, 500);
      if (r < 35) begin
        queue_cmd(rvs_pkg::KIND_ADD,
                  $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 45),
                  d - 400, 0, 0);
      end else if (r < 65) begin
        queue_cmd(rvs_pkg::KIND_REVIEW, $urandom, d, $urandom_range(0, 31), $urandom);
      end else if (r < 95) begin
        queue_cmd(rvs_pkg::KIND_DUE, $urandom, d, $urandom,
                  $urandom_range(0, 9) == 0 ? 32 : $urandom_range(0, 12));
      end else begin
        queue_cmd(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int base;
    cmd.valid = 1'b0;
    cmd.kind = rvs_pkg::KIND_ADD;
    cmd.page = '0;
    cmd.day = '0;
    cmd.entry_index = '0;
    cmd.max_out = '0;
    res.ready = 1'b0;
    rst = 1'b1;
    errors = 0;
    holds_asked = 0;
    holds_served = 0;
    quiet = 0;
    tbl_count = 0;
    top_page = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Empty table, zero page, extreme days and pages, step saturation.
    queue_cmd(rvs_pkg::KIND_DUE, 0, 20'hFFFFF, 0, 32);
    queue_cmd(rvs_pkg::KIND_REVIEW, 0, 0, 0, 0);
    queue_cmd(KIND_UNUSED, 16'hFFFF, 20'hFFFFF, 31, 63);
    queue_cmd(rvs_pkg::KIND_ADD, 0, 0, 0, 0);
    queue_cmd(rvs_pkg::KIND_DUE, 0, 0, 0, 32);
    queue_cmd(rvs_pkg::KIND_DUE, 0, 1, 0, 0);
    queue_cmd(rvs_pkg::KIND_DUE, 0, 1, 0, 32);
    queue_cmd(rvs_pkg::KIND_ADD, 16'hFFFF, 20'hFFFFF, 0, 0);
    queue_cmd(rvs_pkg::KIND_ADD, 0, 3, 0, 0);
    for (int i = 0; i < 8; i++) queue_cmd(rvs_pkg::KIND_REVIEW, 0, 0, 0, 0);
    queue_cmd(rvs_pkg::KIND_REVIEW, 0, 0, 31, 0);
    queue_cmd(rvs_pkg::KIND_REVIEW, 0, 0, 2, 0);
    queue_cmd(rvs_pkg::KIND_ADD, 7, 5, 0, 0);
    queue_cmd(rvs_pkg::KIND_ADD, 6, 5, 0, 0);
    queue_cmd(rvs_pkg::KIND_DUE, 0, 20'hFFFFF, 0, 1);
    queue_cmd(rvs_pkg::KIND_DUE, 0, 20'hFFFFF, 0, 32);
    wait_drained();

    // Fill the table past full with a mix of new and repeated pages.
    base = $urandom_range(400, 20'hFFFFF - 600);
    for (int i = 0; i < 36; i++) begin
      queue_cmd(rvs_pkg::KIND_ADD, $urandom_range(1, 45), base, 0, 0);
    end
    queue_random(30, base);
    wait_drained();

    // Long receiver hold while the sender keeps long due lists coming.
    holds_asked++;
    for (int i = 0; i < 4; i++) begin
      queue_cmd(rvs_pkg::KIND_DUE, 0, base + 500, 0, 32);
      queue_cmd(rvs_pkg::KIND_REVIEW, 0, 0, $urandom_range(0, 31), 0);
    end
    wait_drained();

    base = $urandom_range(400, 20'hFFFFF - 600);
    queue_random(60, base);
    wait_drained();
    quiet = 1;
    queue_random(25, base + 200);
    wait_drained();
    repeat (200) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
